>>> rtl/wfgcd_pkg.sv
// ----------------------------------------------------------------------------
// wfgcd_pkg: shared types and constants for the wait-for graph cycle detector
// Sizes of the row store, the item passed from front to back, and its kinds.
// ----------------------------------------------------------------------------
package wfgcd_pkg;

  // Row store depth (nodes that can be held)
  localparam int MaxNodes  = 16;
  // Width of one adjacency row as it arrives
  localparam int RowBits   = 16;
  // Nodes that can take part in a check
  localparam int LiveW     = (MaxNodes < RowBits) ? MaxNodes : RowBits;
  // Store address width
  localparam int NodeIdxW  = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;

  // Field widths fixed by the interface
  localparam int RowIdxW   = 4;
  localparam int CountW    = 5;
  localparam int InDataW   = 24;  // row_index + row_edges, padded to bytes
  localparam int OutDataW  = 8;   // cycle_found, padded to a byte

  // Queue between front and back; depth is a power of two
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;

  // Node count after reset
  localparam logic [CountW-1:0] NodeCountReset = CountW'(16);

  // What a request asks the back end to do
  typedef enum logic {
    KIND_ROW  = 1'b0,  // store the row only
    KIND_LAST = 1'b1   // store the row, then run the check
  } item_kind_e;

  typedef struct packed {
    item_kind_e           kind;
    logic                 in_range;
    logic [RowIdxW-1:0]   idx;
    logic [RowBits-1:0]   edges;
  } item_t;

  // Handshake between two stages
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_req_t;

endpackage

>>> rtl/wfgcd_front.sv
// ----------------------------------------------------------------------------
// wfgcd_front: input stage of the cycle detector
// Registers each incoming row, tags its kind and whether it lands in the store.
// ----------------------------------------------------------------------------
module wfgcd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wfgcd_pkg::RowIdxW-1:0]      in_idx_i,
  input  logic [wfgcd_pkg::RowBits-1:0]      in_edges_i,
  input  logic                               in_last_i,
  output wfgcd_pkg::item_req_t               push_o,
  input  logic                               push_ready_i
);
  import wfgcd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;
  logic  drain;

  // Move the held request on when the queue has room
  assign drain      = valid_q && push_ready_i;
  assign in_ready_o = !valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // Classify the incoming row
  always_comb begin
    item_d          = item_q;
    item_d.kind     = in_last_i ? KIND_LAST : KIND_ROW;
    item_d.in_range = (32'(in_idx_i) < MaxNodes);
    item_d.idx      = in_idx_i;
    item_d.edges    = in_edges_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (drain) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_o.valid = valid_q;
  assign push_o.item  = item_q;

endmodule

>>> rtl/wfgcd_queue.sv
// ----------------------------------------------------------------------------
// wfgcd_queue: short request queue between front and back
// Lets the front keep loading rows while the back runs a check.
// ----------------------------------------------------------------------------
module wfgcd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wfgcd_pkg::item_req_t  push_i,
  output logic                  push_ready_o,
  output wfgcd_pkg::item_req_t  pop_o,
  input  logic                  pop_ready_i
);
  import wfgcd_pkg::*;

  item_t                entries_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]       count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_o.valid && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign pop_o.valid = (count_q != '0);
  assign pop_o.item  = entries_q[rd_ptr_q];

endmodule

>>> rtl/wfgcd_back.sv
// ----------------------------------------------------------------------------
// wfgcd_back: row store, cycle check and result register
// Stores rows; on a last row peels off nodes with no live successor, one
// pass per cycle, until nothing changes. Any survivor means a cycle.
// ----------------------------------------------------------------------------
module wfgcd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wfgcd_pkg::CountW-1:0]       cfg_data_i,
  input  wfgcd_pkg::item_req_t               pop_i,
  output logic                               pop_ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_cycle_o
);
  import wfgcd_pkg::*;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_CHECK = 1'b1
  } state_e;

  state_e               state_q;
  logic [CountW-1:0]    node_count_q;
  logic [RowBits-1:0]   rows_q [MaxNodes];
  logic [LiveW-1:0]     live_q;
  logic [LiveW-1:0]     live_init;
  logic [LiveW-1:0]     live_next;
  logic [CountW-1:0]    nodes_used;
  logic                 out_valid_q;
  logic                 out_cycle_q;
  logic                 pop;
  logic                 out_free;
  logic                 settled;

  assign cfg_ready_o = 1'b1;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_i.valid && pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Clamp node count to what the store can check
  assign nodes_used = (32'(node_count_q) > LiveW) ? CountW'(LiveW) : node_count_q;

  // Start mask: every node in use is live
  always_comb begin
    for (int i = 0; i < LiveW; i++) begin
      live_init[i] = (32'(nodes_used) > i);
    end
  end

  // One pass: drop each live node whose row hits no live node
  always_comb begin
    for (int i = 0; i < LiveW; i++) begin
      live_next[i] = live_q[i] && ((rows_q[i][LiveW-1:0] & live_q) != '0);
    end
  end

  assign settled = (live_next == live_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= NodeCountReset;
      live_q       <= '0;
      out_valid_q  <= 1'b0;
      out_cycle_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !(state_q == ST_CHECK && settled)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop && pop_i.item.kind == KIND_LAST) begin
            live_q  <= live_init;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!settled) begin
            live_q <= live_next;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_cycle_q <= (live_q != '0);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Row store, written as requests leave the queue
  always_ff @(posedge clk_i) begin
    if (pop && pop_i.item.in_range) begin
      rows_q[NodeIdxW'(pop_i.item.idx)] <= pop_i.item.edges;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_cycle_o = out_cycle_q;

endmodule

>>> rtl/wait_for_graph_cycle_detect.sv
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detect: deadlock check over a wait-for graph
// Loads adjacency rows and, after the row marked last, reports whether the
// nodes in use hold a directed cycle.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Notes
//  s_axis    in   tdata[3:0] row_index, [19:4] row_edges    tlast = last_row
//  m_axis    out  tdata[0] cycle_found                      one per last row
//  cfg       in   cfg_data_i[4:0] node_count                always ready
//
//  Rows are taken one per cycle through a one-entry input register and a
//  two-entry queue. A last row starts the check once it leaves the queue:
//  peeling passes run until the live set stops changing. Rows keep loading
//  into the queue during a check and stall once it is full. The result waits
//  in an output register; a new check will not finish until it is taken.
//  Reset sets node_count to 16 and clears no rows.
// ----------------------------------------------------------------------------
module wait_for_graph_cycle_detect (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wfgcd_pkg::InDataW-1:0]     s_axis_tdata,   // row_index, row_edges
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wfgcd_pkg::OutDataW-1:0]    m_axis_tdata,   // cycle_found
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wfgcd_pkg::CountW-1:0]      cfg_data_i      // node_count
);
  import wfgcd_pkg::*;

  item_req_t push;
  item_req_t pop;
  logic      push_ready;
  logic      pop_ready;
  logic      cycle_found;

  wfgcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_idx_i     (s_axis_tdata[RowIdxW-1:0]),
    .in_edges_i   (s_axis_tdata[RowIdxW+RowBits-1:RowIdxW]),
    .in_last_i    (s_axis_tlast),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  wfgcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_o        (pop),
    .pop_ready_i  (pop_ready)
  );

  wfgcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .pop_i        (pop),
    .pop_ready_o  (pop_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_cycle_o  (cycle_found)
  );

  assign m_axis_tdata = {{(OutDataW-1){1'b0}}, cycle_found};

endmodule

>>> tb/sv/wait_for_graph_cycle_detect_test.sv
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detect_test: self-checking bench for the cycle detector
// Streams adjacency rows into the block and keeps its own copy of the row
// store and node count. On every last row it peels the graph itself and
// checks the block's verdict. Node counts, idle patterns and one long output
// stall are varied from phase to phase.
// ----------------------------------------------------------------------------
module wait_for_graph_cycle_detect_test;
  import wfgcd_pkg::*;

  localparam int ClkHalf       = 6;
  localparam int TimeoutCycles = 200000;
  localparam int NumPhases     = 12;
  localparam int PhaseItems    = 100;
  localparam int HoldPhase     = 4;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 40;

  // Shapes of generated graphs
  typedef enum int {
    SHAPE_DENSE,
    SHAPE_SPARSE,
    SHAPE_CHAIN,
    SHAPE_LOOP
  } shape_e;

  // One row request as queued for the driver
  typedef struct packed {
    logic [RowIdxW-1:0] idx;
    logic [RowBits-1:0] edges;
    logic               last;
  } row_req_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // row_index, row_edges, zero pad
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // cycle_found, zero pad
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i    = '0;  // node_count

  // Rows waiting to be offered, verdicts waiting to come out
  row_req_t            rows_pending_q [$];
  logic                verdicts_q [$];

  // Shadow of the block's state
  logic [RowBits-1:0]  graph_rows [MaxNodes];
  logic [CountW-1:0]   node_count_q = NodeCountReset;

  int                  mismatch_cnt   = 0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  rows_queued    = 0;
  bit                  tail_is_last   = 1'b0;
  bit                  hold_go        = 1'b0;
  logic                hold_off       = 1'b0;

  wait_for_graph_cycle_detect dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Drop every live node without an edge to any live node, itself included, until stable
  function automatic logic peel_for_cycle();
    int                 n;
    logic [RowBits-1:0] live;
    logic [RowBits-1:0] next;
    bit                 settled;
    n = (node_count_q > LiveW) ? LiveW : int'(node_count_q);
    live = (n >= RowBits) ? '1 : RowBits'((1 << n) - 1);
    settled = 1'b0;
    for (int p = 0; p < n && !settled; p++) begin
      next = live;
      for (int i = 0; i < n; i++) begin
        if (live[i] && (graph_rows[i] & live) == '0) next[i] = 1'b0;
      end
      if (next == live) settled = 1'b1;
      else live = next;
    end
    return |live;
  endfunction

  // Store an accepted row; a last row yields one verdict
  task automatic load_row(input logic [RowIdxW-1:0] idx, input logic [RowBits-1:0] edges,
                          input logic last);
    if (idx < MaxNodes) graph_rows[idx] = edges;
    if (last) verdicts_q.push_back(peel_for_cycle());
  endtask

  // Driver: present queued rows, hold each until taken
  always @(posedge clk_i or negedge rst_ni) begin : row_driver
    row_req_t req;
    bit       free;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      free = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        load_row(s_axis_tdata[RowIdxW-1:0], s_axis_tdata[RowIdxW +: RowBits], s_axis_tlast);
        free = 1'b1;
      end
      if (free) begin
        if (rows_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = rows_pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InDataW'({req.edges, req.idx});
          s_axis_tlast  <= req.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each verdict with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : verdict_monitor
    logic want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts_q.size() == 0) begin
          flag_mismatch($sformatf("verdict %0b with no check pending", m_axis_tdata[0]));
        end else begin
          want = verdicts_q.pop_front();
          if (m_axis_tdata[0] !== want)
            flag_mismatch($sformatf("cycle_found got %b want %b", m_axis_tdata[0], want));
          if (m_axis_tdata[OutDataW-1:1] !== '0)
            flag_mismatch($sformatf("tdata pad bits not zero: %h", m_axis_tdata));
        end
      end
      m_axis_tready <= !(hold_off || $urandom_range(99) < recv_stall_pct);
    end
  end

  // Long output stall, counted here so the input side backs up
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_row(input int idx, input logic [RowBits-1:0] edges,
                           input logic last);
    row_req_t req;
    req.idx   = RowIdxW'(idx);
    req.edges = edges;
    req.last  = last;
    rows_pending_q.push_back(req);
    rows_queued++;
    tail_is_last = last;
  endtask

  // Build row i of a graph with the given shape over n nodes
  function automatic logic [RowBits-1:0] make_row(input shape_e shape, input int i,
                                                  input int n, input int back_src,
                                                  input int back_dst);
    logic [RowBits-1:0] mask;
    logic [RowBits-1:0] r;
    mask = (n >= RowBits) ? '1 : RowBits'((1 << n) - 1);
    r = '0;
    case (shape)
      SHAPE_DENSE: begin
        r = RowBits'($urandom);
      end
      SHAPE_SPARSE: begin
        for (int j = 0; j < RowBits; j++) if ($urandom_range(n + 1) == 0) r[j] = 1'b1;
      end
      default: begin
        // forward edges with a chain through every node; a loop graph adds one back edge
        for (int j = i + 1; j < n; j++) if ($urandom_range(2) == 0) r[j] = 1'b1;
        if (i + 1 < n) r[i + 1] = 1'b1;
        if (shape == SHAPE_LOOP && i == back_src) r[back_dst] = 1'b1;
      end
    endcase
    // add bits the block must ignore
    if ($urandom_range(3) == 0) r = r | (RowBits'($urandom) & ~mask);
    return r;
  endfunction

  // Queue one frame: mostly full graphs, some partial rewrites, some stray rows
  task automatic queue_frame(input int n);
    int     order [$];
    int     draw;
    int     bs;
    int     bd;
    int     k;
    int     tmp;
    int     idx;
    shape_e shape;
    draw  = $urandom_range(99);
    shape = shape_e'($urandom_range(3));
    bs    = (n > 0) ? $urandom_range(n - 1) : 0;
    bd    = $urandom_range(bs);
    if (draw < 75) begin
      for (int i = 0; i < n; i++) order.push_back(i);
      if (n < RowBits) begin
        repeat ($urandom_range(2)) order.push_back($urandom_range(RowBits - 1, n));
      end
      for (int i = order.size() - 1; i > 0; i--) begin
        k = $urandom_range(i);
        tmp = order[i];
        order[i] = order[k];
        order[k] = tmp;
      end
      if (order.size() == 0) order.push_back($urandom_range(RowBits - 1));
      foreach (order[i])
        queue_row(order[i], make_row(shape, order[i], n, bs, bd), i == order.size() - 1);
    end else if (draw < 90) begin
      repeat ($urandom_range(3)) begin
        idx = $urandom_range(RowBits - 1);
        queue_row(idx, make_row(shape, idx, n, bs, bd), 1'b0);
      end
      idx = $urandom_range(RowBits - 1);
      queue_row(idx, make_row(shape, idx, n, bs, bd), 1'b1);
    end else begin
      repeat ($urandom_range(1, 3))
        queue_row($urandom_range(RowBits - 1), RowBits'($urandom), 1'b0);
    end
  endtask

  // Wait until every row is taken and every verdict is out, then settle
  task automatic drain();
    while (rows_pending_q.size() != 0 || s_axis_tvalid || verdicts_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [CountW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    node_count_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CountW-1:0] planned_count(input int p);
    case (p)
      0:       return CountW'(1);
      1:       return CountW'(16);
      2:       return CountW'(0);
      3:       return CountW'(2);
      4:       return CountW'(31);
      5:       return CountW'(7);
      6:       return CountW'(16);
      7:       return CountW'(17);
      8:       return CountW'(1);
      10:      return CountW'(12);
      11:      return CountW'(16);
      default: return CountW'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    logic [CountW-1:0] count;
    int                n;
    int                goal;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset node count, every row written first, extreme rows
    @(negedge clk_i);
    for (int i = 0; i < RowBits - 1; i++) queue_row(i, '0, 1'b0);
    queue_row(RowBits - 1, '1, 1'b1);            // self-loop plus all edges
    queue_row(RowBits - 1, '0, 1'b0);
    queue_row(0, RowBits'(1), 1'b1);             // lone self-loop on node 0
    queue_row(0, RowBits'(16'hFFFE), 1'b1);      // fan out into sinks only
    queue_row(RowBits - 1, RowBits'(1), 1'b1);   // two-node cycle 0 <-> 15
    queue_row(0, '0, 1'b1);                      // only the edge 15 -> 0 is left, no cycle
    drain();

    // Random phases over node counts and idle patterns
    for (int p = 0; p < NumPhases; p++) begin
      count = planned_count(p);
      write_node_count(count);
      n = (count > LiveW) ? LiveW : int'(count);
      @(negedge clk_i);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (p == HoldPhase) hold_go = 1'b1;
      goal = rows_queued + PhaseItems;
      while (rows_queued < goal) queue_frame(n);
      // close with a last row so nothing is left in the store unchecked
      if (!tail_is_last) queue_row($urandom_range(RowBits - 1), RowBits'($urandom), 1'b1);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
